// ----- hdl/esmi_pkg.sv -----
// shared types and constants for the extent set block
// no dependencies
package esmi_pkg;

	localparam int SLOTS = 8;
	localparam int IDXW  = $clog2(SLOTS);
	localparam int PW    = $clog2(SLOTS + 1);

	localparam logic       CMD_ADD    = 1'b0;
	localparam logic       CMD_CHECK  = 1'b1;

	localparam logic [2:0] ACT_CHECK  = 3'd0;
	localparam logic [2:0] ACT_UNION  = 3'd1;
	localparam logic [2:0] ACT_INSERT = 3'd2;
	localparam logic [2:0] ACT_ABSORB = 3'd3;
	localparam logic [2:0] ACT_FUSE   = 3'd4;

	typedef struct packed {
		logic        command;
		logic [63:0] range_start;
		logic [63:0] range_end;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] action;
		logic [5:0] slot_written;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_WRITE,
		CELL_SET_FIRST,
		CELL_SET_LAST,
		CELL_FREE
	} cell_op_t;

	typedef struct packed {
		logic        used;
		logic [63:0] first;
		logic [63:0] last;
	} cell_data_t;

	typedef struct packed {
		logic ov;
		logic hit;
		logic gt;
	} cell_flags_t;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] wr_first;
		logic [63:0] wr_last;
	} bcast_t;

endpackage

// ----- hdl/esmi_cell.sv -----
// one slot of the extent chain: holds an extent, compares it, copies from a neighbor
// depends on esmi_pkg
module esmi_cell import esmi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_op_t    op,
	input  bcast_t      bc,
	input  cell_data_t  left,
	input  cell_data_t  right,
	output cell_data_t  data,
	output cell_flags_t flags
);

	logic        used_q;
	logic [63:0] first_q;
	logic [63:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else begin
			case (op)
				CELL_FROM_LEFT:  used_q <= left.used;
				CELL_FROM_RIGHT: used_q <= right.used;
				CELL_WRITE:      used_q <= 1'b1;
				CELL_FREE:       used_q <= 1'b0;
				default:         used_q <= used_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_FROM_LEFT: begin
				first_q <= left.first;
				last_q  <= left.last;
			end
			CELL_FROM_RIGHT: begin
				first_q <= right.first;
				last_q  <= right.last;
			end
			CELL_WRITE: begin
				first_q <= bc.wr_first;
				last_q  <= bc.wr_last;
			end
			CELL_SET_FIRST: first_q <= bc.wr_first;
			CELL_SET_LAST:  last_q  <= bc.wr_last;
			default: ;
		endcase
	end

	assign data.used  = used_q;
	assign data.first = first_q;
	assign data.last  = last_q;

	assign flags.ov  = used_q && (first_q <= bc.b) && (bc.a <= last_q);
	assign flags.hit = used_q && (bc.a >= first_q) && (bc.a <= last_q);
	assign flags.gt  = used_q && (first_q > bc.a);

endmodule

// ----- hdl/extent_set_merge_insert.sv -----
// steps to the output transfer: compare, decode, then done for check; union and insert add a
// union or seat step; a full set adds gap scan, neighbor and decide, and reseats on a fuse
// throughput: one item at a time; the gap scan walks one slot pair per cycle
// a result waits in an output register while the next item is taken
// reset: arst_n clears all used marks and control at once, extents stay undefined
// depends on esmi_pkg and esmi_cell
module extent_set_merge_insert import esmi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_CMP, S_DEC, S_UNION, S_SEAT, S_GAP, S_NB, S_DECIDE, S_DONE
	} state_t;

	state_t state_q;

	// item registers
	logic              cmd_q;
	logic [63:0]       a_q;
	logic [63:0]       b_q;
	logic [SLOTS-1:0]  ovv_q;
	logic [SLOTS-1:0]  hitv_q;
	logic [SLOTS-1:0]  gtv_q;
	logic [IDXW-1:0]   low_q;
	logic [IDXW-1:0]   high_q;
	logic [PW-1:0]     p_q;
	logic [IDXW-1:0]   k_q;
	logic [IDXW-1:0]   best_k_q;
	logic [63:0]       best_q;
	logic [63:0]       nb_q;
	logic [IDXW-1:0]   nslot_q;
	logic              wf_q;
	logic              fused_q;
	rsp_t              res_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// chain wiring
	cell_data_t  dv [SLOTS];
	cell_flags_t fv [SLOTS];
	cell_op_t    op_v [SLOTS];
	bcast_t      bc;
	logic [SLOTS-1:0] used_v;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			cell_data_t lft;
			cell_data_t rgt;
			if (gi == 0) begin : g_l0
				assign lft = '0;
			end else begin : g_ln
				assign lft = dv[gi-1];
			end
			if (gi == SLOTS - 1) begin : g_rl
				assign rgt = '0;
			end else begin : g_rn
				assign rgt = dv[gi+1];
			end
			esmi_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.op    (op_v[gi]),
				.bc    (bc),
				.left  (lft),
				.right (rgt),
				.data  (dv[gi]),
				.flags (fv[gi])
			);
			assign used_v[gi] = dv[gi].used;
		end
	endgenerate

	// priority picks over the registered flag vectors
	logic [IDXW-1:0] low_c;
	logic [IDXW-1:0] high_c;
	logic [PW-1:0]   p_c;
	always_comb begin
		low_c  = '0;
		high_c = '0;
		p_c    = PW'(SLOTS);
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (ovv_q[i]) low_c = IDXW'(i);
			if (gtv_q[i]) p_c = PW'(i);
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (ovv_q[i]) high_c = IDXW'(i);
		end
	end

	// free seat search on the live used marks, left side first
	logic            lf;
	logic            rf;
	logic [IDXW-1:0] jl;
	logic [IDXW-1:0] jr;
	logic [IDXW-1:0] pm1;
	logic [IDXW-1:0] pi;
	always_comb begin
		lf = 1'b0;
		rf = 1'b0;
		jl = '0;
		jr = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!used_v[i] && i < int'(p_q)) begin
				lf = 1'b1;
				jl = IDXW'(i);
			end
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_v[i] && i >= int'(p_q)) begin
				rf = 1'b1;
				jr = IDXW'(i);
			end
		end
		pm1 = IDXW'(p_q - PW'(1));
		pi  = IDXW'(p_q);
	end

	// union bounds
	logic [63:0] ua;
	logic [63:0] ub;
	always_comb begin
		ua = (dv[low_q].first < a_q) ? dv[low_q].first : a_q;
		ub = (dv[high_q].last > b_q) ? dv[high_q].last : b_q;
	end

	// gap between slot k and k+1
	logic [63:0] gap;
	assign gap = dv[IDXW'(k_q + IDXW'(1))].first - dv[k_q].last;

	// gap from the new extent to its neighbor
	logic [63:0]     left_gap;
	logic [63:0]     right_gap;
	logic [63:0]     nb_c;
	logic [IDXW-1:0] nslot_c;
	logic            wf_c;
	always_comb begin
		left_gap  = a_q - dv[pm1].last;
		right_gap = dv[pi].first - b_q;
		if (p_q == '0) begin
			nslot_c = '0;
			wf_c    = 1'b1;
			nb_c    = dv[0].first - b_q;
		end else if (p_q == PW'(SLOTS)) begin
			nslot_c = IDXW'(SLOTS - 1);
			wf_c    = 1'b0;
			nb_c    = a_q - dv[SLOTS-1].last;
		end else if (left_gap <= right_gap) begin
			nslot_c = pm1;
			wf_c    = 1'b0;
			nb_c    = left_gap;
		end else begin
			nslot_c = pi;
			wf_c    = 1'b1;
			nb_c    = right_gap;
		end
	end

	logic absorb;
	assign absorb = nb_q < best_q;

	// cell commands
	always_comb begin
		bc.a        = a_q;
		bc.b        = b_q;
		bc.wr_first = a_q;
		bc.wr_last  = b_q;
		for (int i = 0; i < SLOTS; i++) op_v[i] = CELL_HOLD;
		case (state_q)
			S_UNION: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (ovv_q[i]) op_v[i] = CELL_FREE;
				end
				op_v[low_q] = CELL_WRITE;
				bc.wr_first = ua;
				bc.wr_last  = ub;
			end
			S_SEAT: begin
				if (lf) begin
					// shift left toward the free slot, seat right before the gap
					for (int i = 0; i < SLOTS; i++) begin
						if (i >= int'(jl) && i < int'(pm1)) op_v[i] = CELL_FROM_RIGHT;
					end
					op_v[pm1] = CELL_WRITE;
				end else if (rf) begin
					// shift right toward the free slot, seat right after the gap
					for (int i = 0; i < SLOTS; i++) begin
						if (i > int'(pi) && i <= int'(jr)) op_v[i] = CELL_FROM_LEFT;
					end
					op_v[pi] = CELL_WRITE;
				end
			end
			S_DECIDE: begin
				if (absorb) begin
					op_v[nslot_q] = wf_q ? CELL_SET_FIRST : CELL_SET_LAST;
				end else begin
					// fuse the closest old pair, freeing the upper slot
					op_v[best_k_q] = CELL_SET_LAST;
					op_v[IDXW'(best_k_q + IDXW'(1))] = CELL_FREE;
					bc.wr_last = dv[IDXW'(best_k_q + IDXW'(1))].last;
				end
			end
			default: ;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			fused_q     <= 1'b0;
		end else begin
			// the done step reloads the output register itself
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req.command;
						fused_q <= 1'b0;
						// reversed bounds are swapped for add
						if (req.command == CMD_ADD && req.range_end < req.range_start) begin
							a_q <= req.range_end;
							b_q <= req.range_start;
						end else begin
							a_q <= req.range_start;
							b_q <= req.range_end;
						end
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					for (int i = 0; i < SLOTS; i++) begin
						ovv_q[i]  <= fv[i].ov;
						hitv_q[i] <= fv[i].hit;
						gtv_q[i]  <= fv[i].gt;
					end
					state_q <= S_DEC;
				end
				S_DEC: begin
					low_q  <= low_c;
					high_q <= high_c;
					p_q    <= p_c;
					if (cmd_q == CMD_CHECK) begin
						res_q.hit          <= |hitv_q;
						res_q.action       <= ACT_CHECK;
						res_q.slot_written <= '0;
						state_q            <= S_DONE;
					end else if (|ovv_q) begin
						state_q <= S_UNION;
					end else begin
						state_q <= S_SEAT;
					end
				end
				S_UNION: begin
					res_q.hit          <= 1'b0;
					res_q.action       <= ACT_UNION;
					res_q.slot_written <= 6'(low_q);
					state_q            <= S_DONE;
				end
				S_SEAT: begin
					res_q.hit    <= 1'b0;
					res_q.action <= fused_q ? ACT_FUSE : ACT_INSERT;
					if (lf) begin
						res_q.slot_written <= 6'(pm1);
						state_q            <= S_DONE;
					end else if (rf) begin
						res_q.slot_written <= 6'(pi);
						state_q            <= S_DONE;
					end else begin
						k_q     <= '0;
						state_q <= S_GAP;
					end
				end
				S_GAP: begin
					// lowest pair wins on equal gaps
					if (k_q == '0 || gap < best_q) begin
						best_q   <= gap;
						best_k_q <= k_q;
					end
					if (k_q == IDXW'(SLOTS - 2)) begin
						state_q <= S_NB;
					end else begin
						k_q <= IDXW'(k_q + IDXW'(1));
					end
				end
				S_NB: begin
					nb_q    <= nb_c;
					nslot_q <= nslot_c;
					wf_q    <= wf_c;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (absorb) begin
						res_q.hit          <= 1'b0;
						res_q.action       <= ACT_ABSORB;
						res_q.slot_written <= 6'(nslot_q);
						state_q            <= S_DONE;
					end else begin
						fused_q <= 1'b1;
						state_q <= S_SEAT;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// union leaves its target slot used
	a_union_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UNION) |=> used_v[low_q])
		else $error("union slot not used");

	// after fusing a pair a free slot must exist for the seat step
	a_fuse_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEAT && fused_q) |-> (lf || rf))
		else $error("no free slot after fuse");

	// hit is only reported for check results
	a_hit_check: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.action != ACT_CHECK) |-> !rsp_q.hit)
		else $error("hit on add result");

	// a new transfer is only taken when no item is at work
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_CMP))
		else $error("accept did not start work");

endmodule

// ----- bench/tb_extent_set_merge_insert.sv -----
// self-checking bench for the extent set block: random and directed add/check items
// depends on esmi_pkg and extent_set_merge_insert
module tb_extent_set_merge_insert;
	import esmi_pkg::*;

	// expected responses and mismatch bookkeeping
	class extent_scoreboard;
		rsp_t pending[$];
		int   errors;

		function void note_request(rsp_t exp_rsp);
			pending.push_back(exp_rsp);
		endfunction

		function void check_response(rsp_t got);
			rsp_t exp_rsp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response %h", got);
				return;
			end
			exp_rsp = pending.pop_front();
			if (got.hit !== exp_rsp.hit || got.action !== exp_rsp.action ||
			    got.slot_written !== exp_rsp.slot_written) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp hit=%0d act=%0d slot=%0d got hit=%0d act=%0d slot=%0d",
						exp_rsp.hit, exp_rsp.action, exp_rsp.slot_written,
						got.hit, got.action, got.slot_written);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	extent_scoreboard sb = new();

	// predictor copy of the slot array
	bit          mdl_used[SLOTS];
	logic [63:0] mdl_first[SLOTS];
	logic [63:0] mdl_last[SLOTS];
	bit          calm;   // no idling stretch
	bit          tb_fail;

	extent_set_merge_insert i_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #6 clk = ~clk;

	function void move_slot(int dst, int src);
		mdl_used[dst]  = mdl_used[src];
		mdl_first[dst] = mdl_first[src];
		mdl_last[dst]  = mdl_last[src];
	endfunction

	// free a seat next to gap position g, left side first, -1 when none free
	function int free_seat(int g);
		int d, j, m;
		d = (g < SLOTS - 1) ? g : SLOTS - 1;
		for (j = d; j >= 0; j--)
			if (!mdl_used[j])
				break;
		if (j >= 0) begin
			for (m = j; m < d; m++)
				move_slot(m, m + 1);
			mdl_used[d] = 1'b0;
			return d;
		end
		for (j = g + 1; j < SLOTS; j++)
			if (!mdl_used[j])
				break;
		if (j >= SLOTS)
			return -1;
		for (m = j; m > g + 1; m--)
			move_slot(m, m - 1);
		mdl_used[g + 1] = 1'b0;
		return g + 1;
	endfunction

	function void place(int s, logic [63:0] a, logic [63:0] b);
		mdl_first[s] = a;
		mdl_last[s]  = b;
		mdl_used[s]  = 1'b1;
	endfunction

	// compute the response of one item and update the slot copy
	function rsp_t predict_extent(req_t r);
		rsp_t        o;
		logic [63:0] a, b, ua, ub, best, nb, gap, lft, rgt;
		int          low, g, sel, k, nslot, i;
		bit          widen_first;
		o = '0;
		a = r.range_start;
		b = r.range_end;
		low = -1;
		g = SLOTS;
		if (r.command == CMD_CHECK) begin
			o.action = ACT_CHECK;
			for (i = 0; i < SLOTS; i++)
				if (mdl_used[i] && a >= mdl_first[i] && a <= mdl_last[i])
					o.hit = 1'b1;
			return o;
		end
		// reversed bounds are swapped
		if (b < a) begin
			ua = a; a = b; b = ua;
		end
		ua = a;
		ub = b;
		for (i = 0; i < SLOTS; i++) begin
			if (mdl_used[i] && mdl_first[i] <= b && a <= mdl_last[i]) begin
				if (mdl_first[i] < ua) ua = mdl_first[i];
				if (mdl_last[i] > ub) ub = mdl_last[i];
				mdl_used[i] = 1'b0;
				if (low < 0) low = i;
			end
		end
		if (low >= 0) begin
			place(low, ua, ub);
			o.action = ACT_UNION;
			o.slot_written = low[5:0];
			return o;
		end
		for (i = 0; i < SLOTS; i++)
			if (mdl_used[i] && mdl_first[i] > a) begin
				g = i - 1;
				break;
			end
		sel = free_seat(g);
		if (sel >= 0) begin
			place(sel, a, b);
			o.action = ACT_INSERT;
			o.slot_written = sel[5:0];
			return o;
		end
		// full set: smallest old gap, lowest pair on ties
		k = 0;
		best = mdl_first[1] - mdl_last[0];
		for (i = 1; i < SLOTS - 1; i++) begin
			gap = mdl_first[i + 1] - mdl_last[i];
			if (gap < best) begin
				best = gap;
				k = i;
			end
		end
		if (g < 0) begin
			nslot = 0; widen_first = 1'b1; nb = mdl_first[0] - b;
		end else if (g >= SLOTS - 1) begin
			nslot = SLOTS - 1; widen_first = 1'b0; nb = a - mdl_last[SLOTS - 1];
		end else begin
			lft = a - mdl_last[g];
			rgt = mdl_first[g + 1] - b;
			if (lft <= rgt) begin
				nslot = g; widen_first = 1'b0; nb = lft;
			end else begin
				nslot = g + 1; widen_first = 1'b1; nb = rgt;
			end
		end
		if (nb < best) begin
			if (widen_first) mdl_first[nslot] = a;
			else mdl_last[nslot] = b;
			o.action = ACT_ABSORB;
			o.slot_written = nslot[5:0];
			return o;
		end
		mdl_last[k] = mdl_last[k + 1];
		mdl_used[k + 1] = 1'b0;
		sel = free_seat(g);
		if (sel < 0) sel = k + 1;
		place(sel, a, b);
		o.action = ACT_FUSE;
		o.slot_written = sel[5:0];
		return o;
	endfunction

	// one transfer on the request channel, random idle before it
	task send_item(logic cmd, logic [63:0] s, logic [63:0] e);
		req_t r;
		r.command = cmd;
		r.range_start = s;
		r.range_end = e;
		// valid drops only for idle cycles, so back to back items keep it high
		while (!calm && $urandom_range(99) < 34) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(predict_extent(r));
	endtask

	// random value: small window mostly so extents collide, sometimes full range
	function logic [63:0] pick_pos();
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(40);
			default: return 64'(1000 + $urandom_range(300));
		endcase
	endfunction

	// response side: random stall, check each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			rsp_ready <= calm || ($urandom_range(99) >= 34);
		end
	end

	initial begin
		logic [63:0] s, e;
		int n;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: checks on empty set, extremes, reversed, touching, fill and overflow
		send_item(CMD_CHECK, 64'd0, 64'd0);
		send_item(CMD_ADD, 64'd0, 64'd0);
		send_item(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
		send_item(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_item(CMD_ADD, 64'd1, 64'd1);
		send_item(CMD_ADD, 64'd100, 64'd110);
		send_item(CMD_ADD, 64'd111, 64'd120);
		send_item(CMD_ADD, 64'd105, 64'd115);
		send_item(CMD_ADD, 64'd200, 64'd210);
		send_item(CMD_ADD, 64'd300, 64'd310);
		send_item(CMD_ADD, 64'd400, 64'd410);
		send_item(CMD_ADD, 64'd500, 64'd510);
		send_item(CMD_ADD, 64'd600, 64'd610);
		send_item(CMD_ADD, 64'd700, 64'd710);
		send_item(CMD_ADD, 64'd250, 64'd251);
		send_item(CMD_ADD, 64'd612, 64'd615);
		send_item(CMD_ADD, 64'd50, 64'd40);
		send_item(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_FFFF_FFE8);
		send_item(CMD_ADD, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(CMD_CHECK, 64'h5555_AAAA_5555_AAAA, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(CMD_ADD, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555);
		// random part, a calm stretch in the middle
		for (n = 0; n < 900; n++) begin
			calm = (n >= 400 && n < 550);
			s = pick_pos();
			e = ($urandom_range(3) == 0) ? pick_pos() : s + 64'($urandom_range(8));
			send_item(logic'($urandom_range(2) == 0), s, e);
		end
		req_valid <= 1'b0;
		calm = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 20) @(posedge clk);
		tb_fail = (sb.errors != 0);
		if (!tb_fail)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 400000);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/esmi_pkg.sv
hdl/esmi_cell.sv
hdl/extent_set_merge_insert.sv
bench/tb_extent_set_merge_insert.sv
